// ----- rtl/ftt_pkg.sv -----
// ftt_pkg: shared types, codes and defaults for the fsm transition table
// no dependencies; used by the interfaces, the cells, the controller and the top level
package ftt_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 8;
   localparam int WORD_WIDTH = 32;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // word that walks along the cell chain, one cell per cycle
   typedef struct packed {
      logic                          active;
      logic [1:0]                    op;
      logic signed [WORD_WIDTH-1:0]  key;
      logic signed [WORD_WIDTH-1:0]  tgt;
      logic                          found;
      logic signed [WORD_WIDTH-1:0]  next;
   } scan_type;

endpackage

// ----- rtl/ftt_ifs.sv -----
// ftt_ifs: valid/ready channel interfaces for request, response and csr words
// depends on ftt_pkg
interface ftt_req_if
   import ftt_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    operation;
   logic signed [WORD_WIDTH-1:0]  input_key;
   logic signed [WORD_WIDTH-1:0]  target_state;

   modport source (output valid, operation, input_key, target_state, input ready);
   modport sink   (input valid, operation, input_key, target_state, output ready);
endinterface

interface ftt_rsp_if
   import ftt_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [WORD_WIDTH-1:0]  next_state;
   logic                          matched;
   logic [1:0]                    status;

   modport source (output valid, next_state, matched, status, input ready);
   modport sink   (input valid, next_state, matched, status, output ready);
endinterface

interface ftt_csr_if
   import ftt_pkg::*;
();
   logic                          valid;
   logic                          ready;
   logic signed [WORD_WIDTH-1:0]  own_state_id;

   modport source (output valid, own_state_id, input ready);
   modport sink   (input valid, own_state_id, output ready);
endinterface

// ----- rtl/ftt_cell.sv -----
// ftt_cell: one table slot (key, target); updates itself as the scan word passes
// depends on ftt_pkg
module ftt_cell
   import ftt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  scan_type                      scan_i,
   input  logic signed [WORD_WIDTH-1:0]  nbr_key,
   input  logic signed [WORD_WIDTH-1:0]  nbr_target,
   output scan_type                      scan_o,
   output logic signed [WORD_WIDTH-1:0]  key_o,
   output logic signed [WORD_WIDTH-1:0]  target_o
);

   logic signed [WORD_WIDTH-1:0] key_ff, key_in;
   logic signed [WORD_WIDTH-1:0] target_ff, target_in;
   scan_type                     scan_ff, scan_in;
   logic                         used;

   assign used = (target_ff != '0);

   always_comb begin
      key_in    = key_ff;
      target_in = target_ff;
      scan_in   = scan_i;
      if (scan_i.active) begin
         unique case (scan_i.op)
            OP_LOOKUP: begin
               if (!scan_i.found && used && (key_ff == scan_i.key)) begin
                  scan_in.found = 1'b1;
                  scan_in.next  = target_ff;
               end
            end
            OP_ADD: begin
               if (!scan_i.found && !used && (scan_i.tgt != '0)) begin
                  key_in        = scan_i.key;
                  target_in     = scan_i.tgt;
                  scan_in.found = 1'b1;
               end
            end
            OP_DELETE: begin
               // once the victim is found every later slot pulls from its neighbor
               if (scan_i.found || (used && (target_ff == scan_i.tgt))) begin
                  key_in        = nbr_key;
                  target_in     = nbr_target;
                  scan_in.found = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         target_ff <= '0;
         scan_ff   <= '0;
      end else begin
         key_ff    <= key_in;
         target_ff <= target_in;
         scan_ff   <= scan_in;
      end
   end

   assign scan_o   = scan_ff;
   assign key_o    = key_ff;
   assign target_o = target_ff;

endmodule

// ----- rtl/ftt_ctrl.sv -----
// ftt_ctrl: request intake, scan launch, response register and own state id csr
// depends on ftt_pkg
module ftt_ctrl
   import ftt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_operation,
   input  logic signed [WORD_WIDTH-1:0]  req_input_key,
   input  logic signed [WORD_WIDTH-1:0]  req_target_state,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [WORD_WIDTH-1:0]  rsp_next_state,
   output logic                          rsp_matched,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   input  logic signed [WORD_WIDTH-1:0]  csr_data,
   output scan_type                      launch_o,
   input  scan_type                      done_i
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESPOND
   } state_type;

   state_type                    state_ff;
   scan_type                     launch_ff;
   logic                         rsp_valid_ff;
   logic signed [WORD_WIDTH-1:0] rsp_next_ff, rsp_next_in;
   logic                         rsp_matched_ff, rsp_matched_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;
   logic signed [WORD_WIDTH-1:0] own_id_ff;

   // response word built from the scan word leaving the last cell
   always_comb begin
      rsp_next_in    = '0;
      rsp_matched_in = 1'b0;
      rsp_status_in  = STATUS_OK;
      unique case (done_i.op)
         OP_LOOKUP: begin
            rsp_next_in    = done_i.found ? done_i.next : own_id_ff;
            rsp_matched_in = done_i.found;
         end
         OP_ADD: begin
            if ((done_i.tgt != '0) && !done_i.found) begin
               rsp_status_in = STATUS_FULL;
            end
         end
         OP_DELETE: begin
            if (!done_i.found) begin
               rsp_status_in = STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         own_id_ff    <= '0;
      end else begin
         if (csr_valid) begin
            own_id_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  launch_ff.active <= 1'b1;
                  launch_ff.op     <= req_operation;
                  launch_ff.key    <= req_input_key;
                  launch_ff.tgt    <= req_target_state;
                  launch_ff.found  <= 1'b0;
                  launch_ff.next   <= '0;
                  state_ff         <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               launch_ff.active <= 1'b0;
               if (done_i.active) begin
                  rsp_next_ff    <= rsp_next_in;
                  rsp_matched_ff <= rsp_matched_in;
                  rsp_status_ff  <= rsp_status_in;
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_RESPOND;
               end
            end
            ST_RESPOND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign launch_o       = launch_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_state = rsp_next_ff;
   assign rsp_matched    = rsp_matched_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

// ----- rtl/fsm_transition_table.sv -----
// fsm_transition_table: top level, controller plus a chain of TABLE_ENTRIES slot cells
// depends on ftt_pkg, ftt_ifs, ftt_cell, ftt_ctrl
//
//   port       dir   word
//   req_chan   in    operation, input_key, target_state
//   rsp_chan   out   next_state, matched, status
//   csr_chan   in    own_state_id (always ready)
//
// one word at a time: the scan word walks the slot chain one cell per cycle,
// and req_chan is not ready for the next item until the response is taken;
// a stalled response holds req_chan off.
// synchronous reset clears the table, own_state_id and all handshakes; no sweep.
module fsm_transition_table
   import ftt_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ftt_req_if.sink     req_chan,
   ftt_rsp_if.source   rsp_chan,
   ftt_csr_if.sink     csr_chan
);

   scan_type                     scan_w [TABLE_ENTRIES+1];
   logic signed [WORD_WIDTH-1:0] key_w [TABLE_ENTRIES];
   logic signed [WORD_WIDTH-1:0] target_w [TABLE_ENTRIES];

   assign csr_chan.ready = 1'b1;

   ftt_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_operation    (req_chan.operation),
      .req_input_key    (req_chan.input_key),
      .req_target_state (req_chan.target_state),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_next_state   (rsp_chan.next_state),
      .rsp_matched      (rsp_chan.matched),
      .rsp_status       (rsp_chan.status),
      .csr_valid        (csr_chan.valid),
      .csr_data         (csr_chan.own_state_id),
      .launch_o         (scan_w[0]),
      .done_i           (scan_w[TABLE_ENTRIES])
   );

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      logic signed [WORD_WIDTH-1:0] nbr_key;
      logic signed [WORD_WIDTH-1:0] nbr_target;

      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign nbr_key    = '0;
         assign nbr_target = '0;
      end else begin : g_mid
         assign nbr_key    = key_w[i+1];
         assign nbr_target = target_w[i+1];
      end

      ftt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .scan_i     (scan_w[i]),
         .nbr_key    (nbr_key),
         .nbr_target (nbr_target),
         .scan_o     (scan_w[i+1]),
         .key_o      (key_w[i]),
         .target_o   (target_w[i])
      );
   end

endmodule
